// ===== rtl/cbs_pkg.sv =====
// Package of the characteristic boundary state block: shared types, latencies,
// register and command codes, and saturating fixed-point helper functions.
// Used by every module under rtl but cbs_delay; depends on nothing.
package cbs_pkg;

  // Signed Q32.32 value and signed Q2.30 normal component.
  typedef logic signed [63:0] q_t;
  typedef logic signed [31:0] nrm_t;

  localparam q_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t QMIN = 64'sh8000_0000_0000_0000;

  // Unit latencies in cycles.
  localparam int MUL_LAT    = 3;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int SQRT_STEPS = 48;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  // Reset value of the heat ratio, 1.4 in Q32.32.
  localparam logic [33:0] HEAT_RESET = 34'd6012954214;

  // Boundary kinds.
  typedef enum logic [1:0] {
    CMD_INLET      = 2'd0,
    CMD_OUTLET     = 2'd1,
    CMD_OUTLET_TRB = 2'd2,
    CMD_WALL       = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_HEAT_RATIO  = 3'd0,
    CFG_OUTLET_PRES = 3'd1,
    CFG_INLET_DENS  = 3'd2,
    CFG_INLET_VX    = 3'd3,
    CFG_INLET_VY    = 3'd4,
    CFG_INLET_PRES  = 3'd5
  } cfg_idx_t;

  // Everything that travels down the pipeline beside the arithmetic units.
  typedef struct packed {
    cmd_t cmd;
    logic bad;
    logic sub;
    q_t   r;
    q_t   u;
    q_t   v;
    q_t   p;
    q_t   t;
    nrm_t nx;
    nrm_t ny;
    q_t   dx;
    q_t   dy;
    q_t   dp;
    q_t   hp;
    q_t   uu;
    q_t   vv;
    q_t   a1;
    q_t   a2;
    q_t   b1;
    q_t   b2;
    q_t   vn;
    q_t   dn;
    q_t   ke;
    q_t   c2;
    q_t   c0;
    q_t   rc0;
    q_t   rc2;
    q_t   wnx;
    q_t   wny;
    q_t   pw;
    q_t   pi;
    q_t   s1;
    q_t   pbw;
    q_t   pb;
    q_t   n1;
    q_t   n2;
    q_t   q1;
    q_t   w;
    q_t   q3;
    q_t   tx;
    q_t   ty;
    q_t   tq;
  } ctx_t;

  // Magnitude of a signed value; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input q_t a);
    mag64 = a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  // Applies a sign to a magnitude and saturates to the signed range.
  function automatic q_t sat_mag(input logic neg, input logic hi_nz,
                                 input logic [63:0] m);
    if (neg) begin
      sat_mag = (hi_nz || (m > 64'h8000_0000_0000_0000)) ? QMIN : q_t'(64'd0 - m);
    end else begin
      sat_mag = (hi_nz || m[63]) ? QMAX : q_t'(m);
    end
  endfunction

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? QMIN : QMAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      sat_sub = s[64] ? QMIN : QMAX;
    end else begin
      sat_sub = s[63:0];
    end
  endfunction

  // Halves a value, truncating toward zero.
  function automatic q_t half(input q_t x);
    q_t y;
    y = x + q_t'({63'd0, x[63]});
    half = y >>> 1;
  endfunction

  // Sign-extends a Q2.30 normal to 64 bits.
  function automatic q_t ext_nrm(input nrm_t n);
    ext_nrm = {{32{n[31]}}, n};
  endfunction

endpackage

// ===== rtl/cbs_delay.sv =====
// Delay line that carries the pipeline context and its valid bit beside a unit.
// Depends on nothing; the width and depth come from the instantiating module.
module cbs_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] din,
  output logic         vout,
  output logic [W-1:0] dout
);

  logic [D-1:0] vld_r;
  logic [W-1:0] dat_r [D];

  // Valid bits are control state and clear at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r[0] <= vin;
      for (int i = 1; i < D; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Payload taps shift along with the valid bits.
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= din;
      for (int i = 1; i < D; i++) begin
        dat_r[i] <= dat_r[i-1];
      end
    end
  end

  assign vout = vld_r[D-1];
  assign dout = dat_r[D-1];

endmodule

// ===== rtl/cbs_mul.sv =====
// Pipelined saturating fixed-point multiplier: (a*b) >> SHIFT, magnitude
// truncated. Built from four 32x32 partial products. Depends on cbs_pkg.
module cbs_mul #(
  parameter int SHIFT = 32
) (
  input  logic          clk,
  input  logic          en,
  input  cbs_pkg::q_t   a,
  input  cbs_pkg::q_t   b,
  output cbs_pkg::q_t   y
);

  logic        neg1_r, neg2_r;
  logic [63:0] ma_r, mb_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  cbs_pkg::q_t y_r;

  logic [127:0] sum;
  logic [127:0] shf;

  // Final sum and shift; saturation is applied in the result register.
  always_comb begin
    sum = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
        + {p11_r, 64'd0};
    shf = sum >> SHIFT;
  end

  // Magnitudes, then partial products, then the result.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[63] ^ b[63];
      ma_r   <= cbs_pkg::mag64(a);
      mb_r   <= cbs_pkg::mag64(b);
      neg2_r <= neg1_r;
      p00_r  <= 64'(ma_r[31:0])  * 64'(mb_r[31:0]);
      p01_r  <= 64'(ma_r[31:0])  * 64'(mb_r[63:32]);
      p10_r  <= 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
      p11_r  <= 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
      y_r    <= cbs_pkg::sat_mag(neg2_r, |shf[127:64], shf[63:0]);
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/cbs_div.sv =====
// Pipelined Q32.32 divider: one restoring step per stage, saturating, with
// the divide-by-zero and overflow results forced. Depends on cbs_pkg.
module cbs_div (
  input  logic        clk,
  input  logic        en,
  input  cbs_pkg::q_t a,
  input  cbs_pkg::q_t b,
  output cbs_pkg::q_t y
);

  localparam int N = cbs_pkg::DIV_STEPS;

  logic [63:0] rem_r [N+1];
  logic [63:0] lo_r  [N+1];
  logic [63:0] q_r   [N+1];
  logic [63:0] mb_r  [N+1];
  logic        neg_r [N+1];
  logic        frc_r [N+1];
  cbs_pkg::q_t fval_r [N+1];
  cbs_pkg::q_t y_r;

  logic [63:0] ma_in, mb_in;
  logic        neg_in, ovf_in;

  always_comb begin
    ma_in  = cbs_pkg::mag64(a);
    mb_in  = cbs_pkg::mag64(b);
    neg_in = a[63] ^ b[63];
    ovf_in = {32'd0, ma_in[63:32]} >= mb_in;
  end

  // Entry stage: operand magnitudes and the forced results.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {32'd0, ma_in[63:32]};
      lo_r[0]  <= {ma_in[31:0], 32'd0};
      q_r[0]   <= '0;
      mb_r[0]  <= mb_in;
      neg_r[0] <= neg_in;
      if (b == '0) begin
        frc_r[0]  <= 1'b1;
        fval_r[0] <= a[63] ? cbs_pkg::QMIN : cbs_pkg::QMAX;
      end else begin
        frc_r[0]  <= ovf_in;
        fval_r[0] <= neg_in ? cbs_pkg::QMIN : cbs_pkg::QMAX;
      end
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [64:0] rem2;
    logic        ge;

    always_comb begin
      rem2 = {rem_r[k-1], lo_r[k-1][63]};
      ge   = rem2 >= {1'b0, mb_r[k-1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 64'(rem2 - {1'b0, mb_r[k-1]}) : rem2[63:0];
        lo_r[k]   <= {lo_r[k-1][62:0], 1'b0};
        q_r[k]    <= {q_r[k-1][62:0], ge};
        mb_r[k]   <= mb_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        frc_r[k]  <= frc_r[k-1];
        fval_r[k] <= fval_r[k-1];
      end
    end
  end

  // Sign and saturation of the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= frc_r[N] ? fval_r[N] : cbs_pkg::sat_mag(neg_r[N], 1'b0, q_r[N]);
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/cbs_sqrt.sv =====
// Pipelined square root of a Q32.32 value: two radicand bits per stage,
// floor of the exact root, zero for values that are not positive.
// Depends on cbs_pkg.
module cbs_sqrt (
  input  logic        clk,
  input  logic        en,
  input  cbs_pkg::q_t x,
  output logic [47:0] y
);

  localparam int N = cbs_pkg::SQRT_STEPS;

  logic [51:0] rem_r  [N+1];
  logic [47:0] root_r [N+1];
  logic [95:0] rad_r  [N+1];

  // Entry stage: radicand is the value shifted up by 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= (x[63] || (x == '0)) ? 96'd0 : {1'b0, x[62:0], 32'd0};
    end
  end

  // One root bit per stage.
  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [51:0] rem2;
    logic [51:0] trial;
    logic        ge;

    always_comb begin
      rem2  = {rem_r[k-1][49:0], rad_r[k-1][95:94]};
      trial = {2'b00, root_r[k-1], 2'b01};
      ge    = rem2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem2 - trial) : rem2;
        root_r[k] <= {root_r[k-1][46:0], ge};
        rad_r[k]  <= {rad_r[k-1][93:0], 2'b00};
      end
    end
  end

  assign y = root_r[N];

endmodule

// ===== rtl/characteristic_boundary_state.sv =====
// Characteristic boundary state: ghost state of one 2-D Euler boundary face.
// Input channel in_*: in_tuser carries the boundary kind, in_tdata the
// interior density, velocities, pressure, turbulence variable and the unit
// face normal. Result channel out_*: the ghost state in out_tdata, the
// subsonic and bad-state flags in out_tuser. cfg_* writes the heat ratio,
// outlet pressure and free-stream registers; the user must write them only
// while the block is idle, which the block itself does not enforce.
// Two divider ranks of 66 stages each, a square root of 49 stages, four
// multiplier ranks of 3 stages each and six add and select stages, all
// registers; one face enters per cycle unless the receiver stalls.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so in_tready falls only while a result waits and the
// receiver stalls; nothing is lost or repeated while stalled.
// Reset clears all valid bits and returns the registers to their defaults
// (heat ratio 1.4, all others zero); no result is shown after reset until
// a new input has gone through the pipeline.
// Depends on cbs_pkg, cbs_delay, cbs_mul, cbs_div and cbs_sqrt.
module characteristic_boundary_state (
  input  logic         clk,
  input  logic         rst_n,
  // Fields from bit 0 up: cell_density, cell_vel_x, cell_vel_y,
  // cell_pressure, cell_turb, normal_x, normal_y.
  input  logic [383:0] in_tdata,
  // Fields from bit 0 up: command.
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: bnd_density, bnd_vel_x, bnd_vel_y, bnd_pressure,
  // bnd_turb.
  output logic [319:0] out_tdata,
  // Fields from bit 0 up: subsonic, bad_state.
  output logic [1:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  localparam int CW = $bits(cbs_pkg::ctx_t);

  logic en;

  // Configuration registers.
  logic [33:0] heat_r;
  logic [62:0] opres_r, idens_r, ipres_r;
  cbs_pkg::q_t ivx_r, ivy_r;
  cbs_pkg::q_t heat, opres, idens, ipres;

  // Pipeline context at each phase boundary.
  cbs_pkg::ctx_t ctx0_nxt, ctx0_r, d1, ctx1, ctx2_nxt, ctx2_r, d3, ctx3, d4, ctx4;
  cbs_pkg::ctx_t d5, ctx5, d6, ctx6, ctx7a_nxt, ctx7a_r, ctx7b_nxt, ctx7b_r;
  cbs_pkg::ctx_t ctx7c_nxt, ctx7c_r, d8, ctx8, d9, ctx9;
  logic v0_r, dv1, v2_r, dv3, dv4, dv5, dv6, v7a_r, v7b_r, v7c_r, dv8, dv9;

  // Unit results.
  cbs_pkg::q_t hp_y, uu_y, vv_y, a1_y, a2_y, b1_y, b2_y, c2_y;
  logic [47:0] c0_y;
  cbs_pkg::q_t rc0_y, rc2_y, wnx_y, wny_y, pw_y, pi_y, q1_y, w_y, q3_y;
  cbs_pkg::q_t tx_y, ty_y, tq_y;

  // Output register.
  logic         out_valid_r;
  logic [319:0] out_data_r;
  logic [1:0]   out_user_r;
  logic [319:0] out_data_nxt;
  logic [1:0]   out_user_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign heat  = {30'd0, heat_r};
  assign opres = {1'b0, opres_r};
  assign idens = {1'b0, idens_r};
  assign ipres = {1'b0, ipres_r};

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r  <= cbs_pkg::HEAT_RESET;
      opres_r <= '0;
      idens_r <= '0;
      ivx_r   <= '0;
      ivy_r   <= '0;
      ipres_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbs_pkg::CFG_HEAT_RATIO:  heat_r  <= cfg_wdata[33:0];
        cbs_pkg::CFG_OUTLET_PRES: opres_r <= cfg_wdata[62:0];
        cbs_pkg::CFG_INLET_DENS:  idens_r <= cfg_wdata[62:0];
        cbs_pkg::CFG_INLET_VX:    ivx_r   <= cfg_wdata;
        cbs_pkg::CFG_INLET_VY:    ivy_r   <= cfg_wdata;
        cbs_pkg::CFG_INLET_PRES:  ipres_r <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  // Input stage: unpack the transaction, flag a bad state and form the velocity
  // and pressure differences against the free stream and outlet.
  always_comb begin
    ctx0_nxt     = '0;
    ctx0_nxt.cmd = cbs_pkg::cmd_t'(in_tuser);
    ctx0_nxt.r   = in_tdata[63:0];
    ctx0_nxt.u   = in_tdata[127:64];
    ctx0_nxt.v   = in_tdata[191:128];
    ctx0_nxt.p   = in_tdata[255:192];
    ctx0_nxt.t   = in_tdata[319:256];
    ctx0_nxt.nx  = in_tdata[351:320];
    ctx0_nxt.ny  = in_tdata[383:352];
    ctx0_nxt.bad = (ctx0_nxt.r <= 0) || (ctx0_nxt.p <= 0);
    ctx0_nxt.dx  = cbs_pkg::sat_sub(ivx_r, ctx0_nxt.u);
    ctx0_nxt.dy  = cbs_pkg::sat_sub(ivy_r, ctx0_nxt.v);
    ctx0_nxt.dp  = cbs_pkg::sat_sub(ctx0_nxt.p, opres);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx0_r <= ctx0_nxt;
    end
  end

  // First multiplier rank: gamma*p, squared velocities, normal projections.
  cbs_delay #(.W(CW), .D(cbs_pkg::MUL_LAT)) u_dl1 (
    .clk, .rst_n, .en, .vin(v0_r), .din(ctx0_r), .vout(dv1), .dout(d1));
  cbs_mul #(.SHIFT(32)) u_hp (.clk, .en, .a(heat), .b(ctx0_r.p), .y(hp_y));
  cbs_mul #(.SHIFT(32)) u_uu (.clk, .en, .a(ctx0_r.u), .b(ctx0_r.u), .y(uu_y));
  cbs_mul #(.SHIFT(32)) u_vv (.clk, .en, .a(ctx0_r.v), .b(ctx0_r.v), .y(vv_y));
  cbs_mul #(.SHIFT(30)) u_a1 (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx0_r.nx)), .b(ctx0_r.u), .y(a1_y));
  cbs_mul #(.SHIFT(30)) u_a2 (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx0_r.ny)), .b(ctx0_r.v), .y(a2_y));
  cbs_mul #(.SHIFT(30)) u_b1 (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx0_r.nx)), .b(ctx0_r.dx), .y(b1_y));
  cbs_mul #(.SHIFT(30)) u_b2 (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx0_r.ny)), .b(ctx0_r.dy), .y(b2_y));

  always_comb begin
    ctx1    = d1;
    ctx1.hp = hp_y;
    ctx1.uu = uu_y;
    ctx1.vv = vv_y;
    ctx1.a1 = a1_y;
    ctx1.a2 = a2_y;
    ctx1.b1 = b1_y;
    ctx1.b2 = b2_y;
  end

  // Sums of the projections and the squared speed.
  always_comb begin
    ctx2_nxt    = ctx1;
    ctx2_nxt.vn = cbs_pkg::sat_add(ctx1.a1, ctx1.a2);
    ctx2_nxt.dn = cbs_pkg::sat_add(ctx1.b1, ctx1.b2);
    ctx2_nxt.ke = cbs_pkg::sat_add(ctx1.uu, ctx1.vv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= dv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx2_nxt;
    end
  end

  // Squared sound speed.
  cbs_delay #(.W(CW), .D(cbs_pkg::DIV_LAT)) u_dl3 (
    .clk, .rst_n, .en, .vin(v2_r), .din(ctx2_r), .vout(dv3), .dout(d3));
  cbs_div u_c2 (.clk, .en, .a(ctx2_r.hp), .b(ctx2_r.r), .y(c2_y));

  always_comb begin
    ctx3    = d3;
    ctx3.c2 = c2_y;
  end

  // Sound speed.
  cbs_delay #(.W(CW), .D(cbs_pkg::SQRT_LAT)) u_dl4 (
    .clk, .rst_n, .en, .vin(dv3), .din(ctx3), .vout(dv4), .dout(d4));
  cbs_sqrt u_c0 (.clk, .en, .x(ctx3.c2), .y(c0_y));

  always_comb begin
    ctx4    = d4;
    ctx4.c0 = {16'd0, c0_y};
  end

  // Second multiplier rank: r*c0, r*c2 and the wall normal components.
  cbs_delay #(.W(CW), .D(cbs_pkg::MUL_LAT)) u_dl5 (
    .clk, .rst_n, .en, .vin(dv4), .din(ctx4), .vout(dv5), .dout(d5));
  cbs_mul #(.SHIFT(32)) u_rc0 (.clk, .en, .a(ctx4.r), .b(ctx4.c0), .y(rc0_y));
  cbs_mul #(.SHIFT(32)) u_rc2 (.clk, .en, .a(ctx4.r), .b(ctx4.c2), .y(rc2_y));
  cbs_mul #(.SHIFT(30)) u_wnx (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx4.nx)), .b(ctx4.vn), .y(wnx_y));
  cbs_mul #(.SHIFT(30)) u_wny (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx4.ny)), .b(ctx4.vn), .y(wny_y));

  always_comb begin
    ctx5     = d5;
    ctx5.rc0 = rc0_y;
    ctx5.rc2 = rc2_y;
    ctx5.wnx = wnx_y;
    ctx5.wny = wny_y;
  end

  // Third multiplier rank: acoustic pressure terms.
  cbs_delay #(.W(CW), .D(cbs_pkg::MUL_LAT)) u_dl6 (
    .clk, .rst_n, .en, .vin(dv5), .din(ctx5), .vout(dv6), .dout(d6));
  cbs_mul #(.SHIFT(32)) u_pw (.clk, .en, .a(ctx5.rc0), .b(ctx5.vn), .y(pw_y));
  cbs_mul #(.SHIFT(32)) u_pi (.clk, .en, .a(ctx5.rc0), .b(ctx5.dn), .y(pi_y));

  always_comb begin
    ctx6    = d6;
    ctx6.pw = pw_y;
    ctx6.pi = pi_y;
  end

  // Mach test and the first pressure sums.
  always_comb begin
    ctx7a_nxt     = ctx6;
    ctx7a_nxt.sub = ctx6.ke < ctx6.c2;
    ctx7a_nxt.s1  = cbs_pkg::sat_add(ipres, ctx6.p);
    ctx7a_nxt.pbw = cbs_pkg::sat_add(ctx6.p, ctx6.pw);
  end

  // Boundary pressure for each kind.
  always_comb begin
    ctx7b_nxt = ctx7a_r;
    case (ctx7a_r.cmd)
      cbs_pkg::CMD_WALL:  ctx7b_nxt.pb = ctx7a_r.pbw;
      cbs_pkg::CMD_INLET: ctx7b_nxt.pb =
                            cbs_pkg::half(cbs_pkg::sat_sub(ctx7a_r.s1, ctx7a_r.pi));
      default:            ctx7b_nxt.pb = opres;
    endcase
  end

  // Numerators of the density and velocity corrections.
  always_comb begin
    ctx7c_nxt = ctx7b_r;
    if (ctx7b_r.cmd == cbs_pkg::CMD_INLET) begin
      ctx7c_nxt.n1 = cbs_pkg::sat_sub(ctx7b_r.pb, ipres);
      ctx7c_nxt.n2 = cbs_pkg::sat_sub(ipres, ctx7b_r.pb);
    end else begin
      ctx7c_nxt.n1 = cbs_pkg::sat_sub(ctx7b_r.pb, ctx7b_r.p);
      ctx7c_nxt.n2 = ctx7b_r.dp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7a_r <= 1'b0;
      v7b_r <= 1'b0;
      v7c_r <= 1'b0;
    end else if (en) begin
      v7a_r <= dv6;
      v7b_r <= v7a_r;
      v7c_r <= v7b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx7a_r <= ctx7a_nxt;
      ctx7b_r <= ctx7b_nxt;
      ctx7c_r <= ctx7c_nxt;
    end
  end

  // Second divider rank: density correction, wave amplitude, turbulence ratio.
  cbs_delay #(.W(CW), .D(cbs_pkg::DIV_LAT)) u_dl8 (
    .clk, .rst_n, .en, .vin(v7c_r), .din(ctx7c_r), .vout(dv8), .dout(d8));
  cbs_div u_q1 (.clk, .en, .a(ctx7c_r.n1), .b(ctx7c_r.c2), .y(q1_y));
  cbs_div u_w  (.clk, .en, .a(ctx7c_r.n2), .b(ctx7c_r.rc0), .y(w_y));
  cbs_div u_q3 (.clk, .en, .a(ctx7c_r.dp), .b(ctx7c_r.rc2), .y(q3_y));

  always_comb begin
    ctx8    = d8;
    ctx8.q1 = q1_y;
    ctx8.w  = w_y;
    ctx8.q3 = q3_y;
  end

  // Fourth multiplier rank: velocity and turbulence corrections.
  cbs_delay #(.W(CW), .D(cbs_pkg::MUL_LAT)) u_dl9 (
    .clk, .rst_n, .en, .vin(dv8), .din(ctx8), .vout(dv9), .dout(d9));
  cbs_mul #(.SHIFT(30)) u_tx (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx8.nx)), .b(ctx8.w), .y(tx_y));
  cbs_mul #(.SHIFT(30)) u_ty (
    .clk, .en, .a(cbs_pkg::ext_nrm(ctx8.ny)), .b(ctx8.w), .y(ty_y));
  cbs_mul #(.SHIFT(32)) u_tq (.clk, .en, .a(ctx8.t), .b(ctx8.q3), .y(tq_y));

  always_comb begin
    ctx9    = d9;
    ctx9.tx = tx_y;
    ctx9.ty = ty_y;
    ctx9.tq = tq_y;
  end

  // Final select of the ghost state by kind, Mach test and bad state.
  always_comb begin
    cbs_pkg::q_t rb, ub, vb, pb, tb;
    logic        sb;
    rb = ctx9.r;
    ub = ctx9.u;
    vb = ctx9.v;
    pb = ctx9.p;
    tb = ctx9.t;
    sb = 1'b0;
    if (!ctx9.bad) begin
      case (ctx9.cmd)
        cbs_pkg::CMD_WALL: begin
          rb = cbs_pkg::sat_add(ctx9.r, ctx9.q1);
          ub = cbs_pkg::sat_sub(ctx9.u, ctx9.wnx);
          vb = cbs_pkg::sat_sub(ctx9.v, ctx9.wny);
          pb = ctx9.pb;
        end
        cbs_pkg::CMD_INLET: begin
          sb = ctx9.sub;
          if (ctx9.sub) begin
            rb = cbs_pkg::sat_add(idens, ctx9.q1);
            ub = cbs_pkg::sat_sub(ivx_r, ctx9.tx);
            vb = cbs_pkg::sat_sub(ivy_r, ctx9.ty);
            pb = ctx9.pb;
          end else begin
            rb = idens;
            ub = ivx_r;
            vb = ivy_r;
            pb = ipres;
          end
        end
        default: begin
          sb = ctx9.sub;
          if (ctx9.sub) begin
            rb = cbs_pkg::sat_add(ctx9.r, ctx9.q1);
            ub = cbs_pkg::sat_add(ctx9.u, ctx9.tx);
            vb = cbs_pkg::sat_add(ctx9.v, ctx9.ty);
            pb = ctx9.pb;
            if (ctx9.cmd == cbs_pkg::CMD_OUTLET_TRB) begin
              tb = cbs_pkg::sat_add(ctx9.t, ctx9.tq);
            end
          end
        end
      endcase
    end
    out_data_nxt = {tb, pb, vb, ub, rb};
    out_user_nxt = {ctx9.bad, sb};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A bad state is never reported as subsonic.
  a_bad_not_sub: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("bad state result flagged subsonic");

  // A bad state result echoes a non-positive density or pressure.
  a_bad_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      ($signed(out_tdata[63:0]) <= 0) || ($signed(out_tdata[255:192]) <= 0))
    else $error("bad state result does not echo the interior state");

  // Wall faces never report subsonic.
  a_wall_sub: assert property (@(posedge clk) disable iff (!rst_n)
    en && dv9 && (ctx9.cmd == cbs_pkg::CMD_WALL) |=> !out_tuser[0])
    else $error("wall face result flagged subsonic");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
